// ===== rtl/core/utfi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfi_pkg: shared types, constants and control store
// Register indexes, reset values, the xorshift32 step and the microprogram
// of the uart transmitter fault injector core.
// ----------------------------------------------------------------------------
package utfi_pkg;

	localparam int PERIOD_W  = 16;
	localparam int SEED_W    = 32;
	localparam int DUR_W     = 18;
	localparam int STEP_W    = 3;
	localparam int DIV_CNT_W = 6;

	localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd9;
	localparam logic [SEED_W-1:0]    SEED_RESET   = 32'hABCD1234;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = 6'd32;

	localparam int SHIFT_A = 13;
	localparam int SHIFT_B = 17;
	localparam int SHIFT_C = 5;

	// configuration register indexes
	localparam logic REG_BIT_PERIOD = 1'b0;
	localparam logic REG_PRNG_SEED  = 1'b1;

	// microprogram step addresses
	localparam logic [STEP_W-1:0] ST_WAIT   = 3'd0;
	localparam logic [STEP_W-1:0] ST_START  = 3'd1;
	localparam logic [STEP_W-1:0] ST_DATA   = 3'd2;
	localparam logic [STEP_W-1:0] ST_PARITY = 3'd3;
	localparam logic [STEP_W-1:0] ST_STOP   = 3'd4;
	localparam logic [STEP_W-1:0] ST_GAP    = 3'd5;

	typedef enum logic [2:0] {
		SYM_START,
		SYM_DATA,
		SYM_PARITY,
		SYM_STOP,
		SYM_GAP
	} sym_t;

	typedef enum logic [1:0] {
		SK_NONE,
		SK_NO_PARITY,
		SK_NO_GAP
	} skip_t;

	typedef struct packed {
		logic              wait_in;   // take a new word from the input
		logic              emit;      // put one symbol in the output register
		sym_t              sym;
		skip_t             skip;      // pass over this step when condition holds
		logic              loop_data; // repeat step until all data bits are out
		logic              need_mod;  // hold until the gap remainder is ready
		logic [STEP_W-1:0] next;
	} ctl_t;

	function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '{wait_in: 1'b0, emit: 1'b0, sym: SYM_START, skip: SK_NONE,
			loop_data: 1'b0, need_mod: 1'b0, next: ST_WAIT};
		case (step)
			ST_WAIT: begin
				c.wait_in = 1'b1;
				c.next    = ST_START;
			end
			ST_START: begin
				c.emit = 1'b1;
				c.sym  = SYM_START;
				c.next = ST_DATA;
			end
			ST_DATA: begin
				c.emit      = 1'b1;
				c.sym       = SYM_DATA;
				c.loop_data = 1'b1;
				c.next      = ST_PARITY;
			end
			ST_PARITY: begin
				c.emit = 1'b1;
				c.sym  = SYM_PARITY;
				c.skip = SK_NO_PARITY;
				c.next = ST_STOP;
			end
			ST_STOP: begin
				c.emit     = 1'b1;
				c.sym      = SYM_STOP;
				c.need_mod = 1'b1;
				c.next     = ST_GAP;
			end
			ST_GAP: begin
				c.emit = 1'b1;
				c.sym  = SYM_GAP;
				c.skip = SK_NO_GAP;
				c.next = ST_WAIT;
			end
			default: begin
				c.next = ST_WAIT;
			end
		endcase
		return c;
	endfunction

	function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] x;
		x = s;
		x = x ^ (x << SHIFT_A);
		x = x ^ (x >> SHIFT_B);
		x = x ^ (x << SHIFT_C);
		return x;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/uart_tx_fault_injector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx_fault_injector_core: uart 8n1 frame generator with fault injection
// Turns one byte plus fault flags into a list of line symbols (level and
// duration in microseconds), driven by a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word: data_byte and the three fault flags.
//   The output channel gives one symbol per word: line_level, duration_us and
//   last_symbol, which marks the final symbol of the frame. A frame is 10 to
//   12 symbols: start, eight data bits lsb first, optional inverted parity,
//   stop, and with timing_distort an optional high gap.
//   Configuration: cfg_we with cfg_index 0 sets bit_period_us, index 1 loads
//   the xorshift32 seed and generator state. Write only while idle.
//   Timing: acceptance moves the sequencer to the start step, which then
//   registers the start symbol once the output register is free. With
//   timing_distort the stop symbol waits for the 32-step serial remainder
//   unit (one quotient bit a cycle).
//   Reset clears the sequencer and output valid flag; bit period returns to 9
//   and the generator to 0xABCD1234. When out_ready is low the symbol holds in
//   the output register and the sequencer stalls at its next emitting step.
// ----------------------------------------------------------------------------
module uart_tx_fault_injector_core
	import utfi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [SEED_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              parity_fault,
	input  wire logic              bad_stop,
	input  wire logic              timing_distort,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   line_level,
	output logic [DUR_W-1:0]       duration_us,
	output logic                   last_symbol
);

	logic [STEP_W-1:0]    step_q;
	logic [2:0]           bit_cnt_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [SEED_W-1:0]    prng_q;
	logic [7:0]           data_q;
	logic                 corrupt_q;
	logic                 bad_stop_q;
	logic                 distort_q;
	logic [PERIOD_W-1:0]  per_q;
	logic [DUR_W-1:0]     div_q;
	logic [SEED_W-1:0]    num_q;
	logic [DUR_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 level_q;
	logic [DUR_W-1:0]     dur_q;
	logic                 last_q;

	ctl_t                 ctl;
	logic [PERIOD_W-1:0]  per_eff;
	logic [DUR_W-1:0]     div_new;
	logic [SEED_W-1:0]    prng_nx;
	logic                 mod_busy;
	logic [DUR_W:0]       trial;
	logic                 trial_ge;
	logic                 gap_nz;
	logic                 slot_free;
	logic                 skip_now;
	logic                 sym_level;
	logic [DUR_W-1:0]     sym_dur;
	logic                 sym_last;

	assign ctl       = ctl_rom(step_q);
	assign per_eff   = (period_q == '0) ? PERIOD_W'(1) : period_q;
	// 3 * period + 1
	assign div_new   = {2'b00, per_eff} + {1'b0, per_eff, 1'b0} + DUR_W'(1);
	assign prng_nx   = xorshift32(prng_q);
	assign mod_busy  = (div_cnt_q != '0);
	assign trial     = {rem_q, num_q[SEED_W-1]};
	assign trial_ge  = (trial >= {1'b0, div_q});
	assign gap_nz    = distort_q && (rem_q != '0);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		case (ctl.skip)
			SK_NO_PARITY: skip_now = !corrupt_q;
			SK_NO_GAP:    skip_now = !gap_nz;
			default:      skip_now = 1'b0;
		endcase
	end

	always_comb begin
		sym_dur  = {2'b00, per_q};
		sym_last = 1'b0;
		case (ctl.sym)
			SYM_START:  sym_level = 1'b0;
			SYM_DATA:   sym_level = data_q[bit_cnt_q];
			SYM_PARITY: sym_level = ~(^data_q);
			SYM_STOP: begin
				sym_level = !bad_stop_q;
				sym_last  = !gap_nz;
			end
			SYM_GAP: begin
				sym_level = 1'b1;
				sym_dur   = rem_q;
				sym_last  = 1'b1;
			end
			default:    sym_level = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_WAIT;
			bit_cnt_q   <= '0;
			period_q    <= PERIOD_RESET;
			prng_q      <= SEED_RESET;
			div_cnt_q   <= '0;
			distort_q   <= 1'b0;
			corrupt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIT_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
					REG_PRNG_SEED:  prng_q   <= cfg_data;
					default:        ;
				endcase
			end

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			// serial remainder, one quotient bit per cycle
			if (mod_busy) begin
				rem_q     <= trial_ge ? DUR_W'(trial - {1'b0, div_q}) : trial[DUR_W-1:0];
				num_q     <= num_q << 1;
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end

			if (ctl.wait_in) begin
				if (in_valid) begin
					data_q     <= data_byte;
					corrupt_q  <= parity_fault;
					bad_stop_q <= bad_stop;
					distort_q  <= timing_distort;
					per_q      <= per_eff;
					div_q      <= div_new;
					rem_q      <= '0;
					if (timing_distort) begin
						prng_q    <= prng_nx;
						num_q     <= prng_nx;
						div_cnt_q <= DIV_STEPS;
					end
					step_q <= ctl.next;
				end
			end else if (skip_now) begin
				step_q <= ctl.next;
			end else if (ctl.emit && slot_free && !(ctl.need_mod && mod_busy)) begin
				out_valid_q <= 1'b1;
				level_q     <= sym_level;
				dur_q       <= sym_dur;
				last_q      <= sym_last;
				if (ctl.loop_data) begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7)
						step_q <= ctl.next;
				end else begin
					step_q <= ctl.next;
				end
			end
		end
	end

	assign in_ready    = ctl.wait_in;
	assign out_valid   = out_valid_q;
	assign line_level  = level_q;
	assign duration_us = dur_q;
	assign last_symbol = last_q;

	// remainder unit is idle whenever a new word can be taken
	a_idle_mod: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mod_busy)
		else $error("remainder unit busy while accepting a word");

	// bit counter only moves inside the data loop
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ST_DATA) |-> (bit_cnt_q == 3'd0))
		else $error("bit counter nonzero outside data step");

	// finished remainder is below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(distort_q && !mod_busy && !in_ready) |-> (rem_q < div_q))
		else $error("gap remainder out of range");

	// a gap symbol is only emitted for a distorted frame with a nonzero gap
	a_gap_src: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_GAP && !skip_now) |-> (distort_q && !mod_busy))
		else $error("gap symbol without distortion");

	// leaving the stop step requires the remainder to be done
	a_stop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_STOP && mod_busy) |=> (step_q == ST_STOP))
		else $error("stop emitted before remainder finished");

endmodule
`default_nettype wire
